@@ design/lru_pkg.sv @@
// Shared constants, types and helper functions of the lattice reconciliation unit.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int LRU_Q       = 12289;
    localparam int LRU_2Q      = 2 * LRU_Q;
    localparam int LRU_4Q      = 4 * LRU_Q;
    localparam int LRU_8Q      = 8 * LRU_Q;
    localparam int LRU_COEF_W  = 14;
    localparam int LRU_COEF_MAX = (2 ** LRU_COEF_W) - 1;
    localparam int LRU_X_W     = 19;
    localparam int LRU_DIST_W  = 16;
    localparam int LRU_SUM_W   = 18;
    localparam int LRU_KMAX    = 9;
    // Largest quotients that the two modes can reach.
    localparam int LRU_HINT_TMAX = (8 * LRU_COEF_MAX + 4) / LRU_Q;
    localparam int LRU_REC_TMAX  = (16 * LRU_Q + 8 * LRU_COEF_MAX) / LRU_4Q;
    localparam int LRU_V0_MAX    = (LRU_HINT_TMAX + 1) / 2;

    localparam logic LRU_KIND_HINT    = 1'b0;
    localparam logic LRU_KIND_RECOVER = 1'b1;

    typedef logic [LRU_X_W-1:0]    lru_x_t;
    typedef logic [LRU_DIST_W-1:0] lru_dist_t;
    typedef logic [1:0]            lru_hint_t;

    // Stage advance strobes and the mode bit held in each stage ahead of the output register.
    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
        logic adv4;
        logic kind1;
        logic kind2;
        logic kind3;
    } lru_ctl_t;

    // Offset 16q - k*q that recover mode adds to 8v.
    function automatic lru_x_t lru_rec_offset(input logic [3:0] k);
        lru_x_t off;
        off = '0;
        for (int j = 0; j <= LRU_KMAX; j++) begin
            if (k == 4'(j)) begin
                off = LRU_X_W'((16 - j) * LRU_Q);
            end
        end
        return off;
    endfunction

    // Quotient of x by q (hint) or 4q (recover), found by threshold compares.
    function automatic logic [3:0] lru_quot(input lru_x_t x, input logic kind);
        logic [3:0] th;
        logic [3:0] tr;
        th = '0;
        tr = '0;
        for (int k = 1; k <= LRU_HINT_TMAX; k++) begin
            if (x >= LRU_X_W'(k * LRU_Q)) begin
                th = 4'(k);
            end
        end
        for (int k = 1; k <= LRU_REC_TMAX; k++) begin
            if (x >= LRU_X_W'(k * LRU_4Q)) begin
                tr = 4'(k);
            end
        end
        return (kind == LRU_KIND_RECOVER) ? tr : th;
    endfunction

    // Rounded multiple: v0 times 2q (hint) or 8q (recover).
    function automatic lru_x_t lru_round_mult(input logic [2:0] v0, input logic kind);
        lru_x_t m;
        m = '0;
        for (int j = 1; j <= LRU_V0_MAX; j++) begin
            if (v0 == 3'(j)) begin
                m = (kind == LRU_KIND_RECOVER) ? LRU_X_W'(j * LRU_8Q) : LRU_X_W'(j * LRU_2Q);
            end
        end
        return m;
    endfunction

endpackage

@@ design/lattice_reconciliation_unit.sv @@
// Top level of the lattice reconciliation unit: pipeline control and four coefficient lanes.
`timescale 1ns / 1ps

// Ring-LWE key reconciliation over q = 12289 for one group of four coefficients
// (positions i, i+256, i+512, i+768) per transaction. With kind = 0 the block
// dithers each coefficient with random_bit, rounds it two ways to a multiple of
// 2q, chooses the rounding by the total distance and returns four 2-bit hints;
// key_bit is then 0. With kind = 1 it folds the received hints into each
// coefficient, measures the distance to the nearest multiple of 8q and returns
// key_bit = 1 when the summed distance is below 8q; the hint outputs are then 0.
// The block is a four-stage pipeline (form x, find the quotient by threshold
// compares, take the rounding distance, sum and select) and accepts one
// transaction every cycle while the result side does not stall; a transaction
// passes the x, quotient and distance registers, then out_valid shows it.
// When the result side stalls, the stages fill up and in_ready drops
// only once every stage holds a transaction, so nothing is lost or repeated.
// The block keeps no state between transactions.
module lattice_reconciliation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [13:0] coef_a,
    input  logic [13:0] coef_b,
    input  logic [13:0] coef_c,
    input  logic [13:0] coef_d,
    input  logic        random_bit,
    input  logic [1:0]  hint_in_a,
    input  logic [1:0]  hint_in_b,
    input  logic [1:0]  hint_in_c,
    input  logic [1:0]  hint_in_d,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  hint_out_a,
    output logic [1:0]  hint_out_b,
    output logic [1:0]  hint_out_c,
    output logic [1:0]  hint_out_d,
    output logic        key_bit
);
    import lru_pkg::*;

    // Valid bit of each stage; stage four is the output register.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic kind1_reg, kind2_reg, kind3_reg;
    lru_ctl_t ctl;

    logic [13:0]       coef [4];
    logic [3:0]        hint_mult [4];
    lru_dist_t [3:0]   distance;
    lru_hint_t [3:0]   round0;
    lru_hint_t [3:0]   round1;

    // A stage can take a new transaction when it is empty or when its
    // occupant moves on in the same cycle.
    always_comb
    begin
        rdy4 = !v4_reg || out_ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;

        ctl.adv1  = in_valid && rdy1;
        ctl.adv2  = v1_reg && rdy2;
        ctl.adv3  = v2_reg && rdy3;
        ctl.adv4  = v3_reg && rdy4;
        ctl.kind1 = kind1_reg;
        ctl.kind2 = kind2_reg;
        ctl.kind3 = kind3_reg;

        v1_next = ctl.adv1 || (v1_reg && !rdy2);
        v2_next = ctl.adv2 || (v2_reg && !rdy3);
        v3_next = ctl.adv3 || (v3_reg && !rdy4);
        v4_next = ctl.adv4 || (v4_reg && !out_ready);
    end

    assign in_ready  = rdy1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // The mode bit travels alongside the lane data.
    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            kind1_reg <= kind;
        end
        if (ctl.adv2)
        begin
            kind2_reg <= kind1_reg;
        end
        if (ctl.adv3)
        begin
            kind3_reg <= kind2_reg;
        end
    end

    // In recover mode the first three lanes subtract q*(2h + h3) and the
    // last lane subtracts q*h3.
    always_comb
    begin
        coef[0] = coef_a;
        coef[1] = coef_b;
        coef[2] = coef_c;
        coef[3] = coef_d;
        hint_mult[0] = {1'b0, hint_in_a, 1'b0} + {2'b00, hint_in_d};
        hint_mult[1] = {1'b0, hint_in_b, 1'b0} + {2'b00, hint_in_d};
        hint_mult[2] = {1'b0, hint_in_c, 1'b0} + {2'b00, hint_in_d};
        hint_mult[3] = {2'b00, hint_in_d};
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        lru_lane u_lane (
            .clk        (clk),
            .ctl        (ctl),
            .kind       (kind),
            .coef       (coef[g]),
            .random_bit (random_bit),
            .hint_mult  (hint_mult[g]),
            .distance   (distance[g]),
            .round0     (round0[g]),
            .round1     (round1[g])
        );
    end

    lru_combine u_combine (
        .clk        (clk),
        .ctl        (ctl),
        .distance   (distance),
        .round0     (round0),
        .round1     (round1),
        .hint_out_a (hint_out_a),
        .hint_out_b (hint_out_b),
        .hint_out_c (hint_out_c),
        .hint_out_d (hint_out_d),
        .key_bit    (key_bit)
    );

`ifndef SYNTH
    // The input side stalls only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("in_ready low while a pipeline stage is empty");

    // A stage that cannot pass its transaction on keeps it.
    a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy4) |=> v3_reg)
        else $error("stage three dropped a stalled transaction");

    // A new result only appears when stage three held a transaction.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg))
        else $error("result appeared without a transaction in stage three");

    // A recovered key bit of one comes only with zero hints.
    a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_bit) |->
            (hint_out_a == 2'b00 && hint_out_b == 2'b00
             && hint_out_c == 2'b00 && hint_out_d == 2'b00))
        else $error("hint fields set on a recover-mode result");
`endif

endmodule

@@ design/lru_lane.sv @@
// One coefficient lane: forms x, finds its quotient and its distance to the rounded multiple.
`timescale 1ns / 1ps

module lru_lane (
    input  logic              clk,
    input  lru_pkg::lru_ctl_t ctl,
    input  logic              kind,
    input  logic [13:0]       coef,
    input  logic              random_bit,
    input  logic [3:0]        hint_mult,
    output lru_pkg::lru_dist_t distance,
    output lru_pkg::lru_hint_t round0,
    output lru_pkg::lru_hint_t round1
);
    import lru_pkg::*;

    lru_x_t     x1_reg;
    lru_x_t     x1_next;
    lru_x_t     x2_reg;
    logic [3:0] t2_reg;
    logic [3:0] t2_next;
    lru_dist_t  dist3_reg;
    lru_dist_t  dist3_next;
    lru_hint_t  r0_reg;
    lru_hint_t  r1_reg;
    logic [2:0] v0;
    lru_x_t     mult;
    lru_x_t     coef8;

    always_comb
    begin
        coef8 = {2'b00, coef, 3'b000};
        if (kind == LRU_KIND_RECOVER)
        begin
            x1_next = coef8 + lru_rec_offset(hint_mult);
        end
        else
        begin
            x1_next = coef8 + LRU_X_W'({random_bit, 2'b00});
        end
    end

    assign t2_next = lru_quot(x1_reg, ctl.kind1);

    always_comb
    begin
        v0   = t2_reg[3:1] + {2'b00, t2_reg[0]};
        mult = lru_round_mult(v0, ctl.kind2);
        if (x2_reg >= mult)
        begin
            dist3_next = LRU_DIST_W'(x2_reg - mult);
        end
        else
        begin
            dist3_next = LRU_DIST_W'(mult - x2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            x1_reg <= x1_next;
        end
        if (ctl.adv2)
        begin
            x2_reg <= x1_reg;
            t2_reg <= t2_next;
        end
        if (ctl.adv3)
        begin
            dist3_reg <= dist3_next;
            r0_reg    <= v0[1:0];
            r1_reg    <= t2_reg[2:1];
        end
    end

    assign distance = dist3_reg;
    assign round0   = r0_reg;
    assign round1   = r1_reg;

endmodule

@@ design/lru_combine.sv @@
// Final stage: sums the four distances, picks the rounding (hint) or the key bit (recover) and registers the result.
`timescale 1ns / 1ps

module lru_combine (
    input  logic                      clk,
    input  lru_pkg::lru_ctl_t         ctl,
    input  lru_pkg::lru_dist_t [3:0]  distance,
    input  lru_pkg::lru_hint_t [3:0]  round0,
    input  lru_pkg::lru_hint_t [3:0]  round1,
    output logic [1:0]                hint_out_a,
    output logic [1:0]                hint_out_b,
    output logic [1:0]                hint_out_c,
    output logic [1:0]                hint_out_d,
    output logic                      key_bit
);
    import lru_pkg::*;

    logic [LRU_SUM_W-1:0] sum;
    logic                 sel;
    lru_hint_t [3:0]      u;
    lru_hint_t [3:0]      hint_next;
    logic                 key_next;
    lru_hint_t [3:0]      hint_reg;
    logic                 key_reg;

    always_comb
    begin
        sum = LRU_SUM_W'(distance[0]) + LRU_SUM_W'(distance[1])
            + LRU_SUM_W'(distance[2]) + LRU_SUM_W'(distance[3]);
        sel = (sum >= LRU_SUM_W'(LRU_2Q));
        for (int i = 0; i < 4; i++)
        begin
            u[i] = sel ? round1[i] : round0[i];
        end
        if (ctl.kind3 == LRU_KIND_RECOVER)
        begin
            hint_next = '0;
            key_next  = (sum < LRU_SUM_W'(LRU_8Q));
        end
        else
        begin
            hint_next[0] = u[0] - u[3];
            hint_next[1] = u[1] - u[3];
            hint_next[2] = u[2] - u[3];
            hint_next[3] = {u[3][0], sel};
            key_next     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv4)
        begin
            hint_reg <= hint_next;
            key_reg  <= key_next;
        end
    end

    assign hint_out_a = hint_reg[0];
    assign hint_out_b = hint_reg[1];
    assign hint_out_c = hint_reg[2];
    assign hint_out_d = hint_reg[3];
    assign key_bit    = key_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench of the lattice reconciliation unit: directed corners, hint/recover pairs, random traffic.
`timescale 1ns / 1ps

// The testbench drives groups of four coefficients into the block through the
// input valid/ready channel and checks every result on the output channel
// against a predictor that runs alongside the block. Each transaction is
// predicted as it is accepted, and the prediction waits in a queue until the
// matching result comes out. The block keeps no state between transactions,
// so the predictor is a pure function of one input transaction.
//
// Stimulus comes from a few named test tasks that run in turn:
//   - hint mode at the coefficient extremes, with both dither values and
//     junk on the hint inputs, which hint mode ignores;
//   - recover mode at the extremes of coefficients and hints, with junk on
//     the dither bit, which recover mode ignores;
//   - hint mode around the point where the summed distance selects the
//     lower rounding;
//   - matched pairs: a hint transaction, then a recover transaction whose
//     coefficients are the same values plus noise and whose hints are the
//     ones the block was just predicted to give, the way the two sides of a
//     key exchange use the block;
//   - fully random transactions, coefficients at or above q included.
// The sender works in bursts with random gaps, and the receiver stalls on
// its own counter-driven pattern, so back pressure reaches every stage.
module tb;

    import lru_pkg::*;

    // No handshake on either side for this many cycles ends the run.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // One input transaction; index 0..3 stands for positions a..d.
    typedef struct packed {
        logic             kind;
        logic [3:0][13:0] coef;
        logic             dither;
        logic [3:0][1:0]  hint;
    } recon_item_t;

    // One result transaction.
    typedef struct packed {
        lru_hint_t [3:0] hint;
        logic            key;
    } recon_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        kind       = LRU_KIND_HINT;
    logic [13:0] coef_a     = '0;
    logic [13:0] coef_b     = '0;
    logic [13:0] coef_c     = '0;
    logic [13:0] coef_d     = '0;
    logic        random_bit = 1'b0;
    logic [1:0]  hint_in_a  = '0;
    logic [1:0]  hint_in_b  = '0;
    logic [1:0]  hint_in_c  = '0;
    logic [1:0]  hint_in_d  = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  hint_out_a;
    logic [1:0]  hint_out_b;
    logic [1:0]  hint_out_c;
    logic [1:0]  hint_out_d;
    logic        key_bit;

    recon_result_t pending_results[$];
    int            err_count   = 0;
    int            idle_cycles = 0;
    logic [8:0]    stall_phase = '0;

    // Sender pacing: when gaps are enabled, a burst of transactions is
    // followed by a random number of idle cycles.
    bit            gaps_on    = 1'b1;
    int            burst_left = 0;

    lattice_reconciliation_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .coef_d     (coef_d),
        .random_bit (random_bit),
        .hint_in_a  (hint_in_a),
        .hint_in_b  (hint_in_b),
        .hint_in_c  (hint_in_c),
        .hint_in_d  (hint_in_d),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hint_out_a (hint_out_a),
        .hint_out_b (hint_out_b),
        .hint_out_c (hint_out_c),
        .hint_out_d (hint_out_d),
        .key_bit    (key_bit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicts the result of one transaction. All arithmetic is exact and
    // unsigned; every intermediate stays positive and well inside 32 bits.
    function automatic recon_result_t reconcile(input recon_item_t it);
        recon_result_t res;
        int unsigned   x;
        int unsigned   quot;
        int unsigned   mult;
        int unsigned   dist_sum;
        int unsigned   round_up[4];
        int unsigned   round_dn[4];
        int unsigned   chosen[4];
        bit            take_lower;
        res      = '0;
        dist_sum = 0;
        if (it.kind == LRU_KIND_HINT) begin
            // Round the dithered value 8v + 4b to a multiple of 2q two ways
            // and measure the distance of the upper rounding.
            for (int i = 0; i < 4; i++) begin
                x           = 8 * it.coef[i] + 4 * it.dither;
                quot        = x / LRU_Q;
                round_up[i] = (quot >> 1) + (quot & 1);
                round_dn[i] = quot >> 1;
                mult        = LRU_2Q * round_up[i];
                dist_sum   += (x >= mult) ? (x - mult) : (mult - x);
            end
            take_lower = (dist_sum >= LRU_2Q);
            for (int i = 0; i < 4; i++) begin
                chosen[i] = take_lower ? round_dn[i] : round_up[i];
            end
            res.hint[0] = lru_hint_t'(chosen[0] - chosen[3]);
            res.hint[1] = lru_hint_t'(chosen[1] - chosen[3]);
            res.hint[2] = lru_hint_t'(chosen[2] - chosen[3]);
            res.hint[3] = lru_hint_t'(take_lower + 2 * chosen[3]);
        end
        else begin
            // Fold the hints into each coefficient and sum the distances to
            // the nearest multiple of 8q.
            for (int i = 0; i < 4; i++) begin
                if (i < 3) begin
                    x = 16 * LRU_Q + 8 * it.coef[i] - LRU_Q * (2 * it.hint[i] + it.hint[3]);
                end
                else begin
                    x = 16 * LRU_Q + 8 * it.coef[i] - LRU_Q * it.hint[3];
                end
                quot      = x / LRU_4Q;
                mult      = ((quot >> 1) + (quot & 1)) * LRU_8Q;
                dist_sum += (x >= mult) ? (x - mult) : (mult - x);
            end
            res.key = (dist_sum < LRU_8Q);
        end
        return res;
    endfunction

    // Coefficients are mostly below q, as the surrounding arithmetic keeps
    // them, with an occasional value anywhere in the 14-bit range.
    function automatic logic [13:0] draw_coef();
        if ($urandom_range(0, 7) == 0) begin
            return 14'($urandom_range(0, LRU_COEF_MAX));
        end
        return 14'($urandom_range(0, LRU_Q - 1));
    endfunction

    // A transaction with every field random; the caller overrides what it needs.
    function automatic recon_item_t random_item();
        recon_item_t it;
        it.kind   = 1'($urandom_range(0, 1));
        it.dither = 1'($urandom_range(0, 1));
        for (int i = 0; i < 4; i++) begin
            it.coef[i] = draw_coef();
            it.hint[i] = 2'($urandom_range(0, 3));
        end
        return it;
    endfunction

    // Presents one transaction at a falling edge and holds it until the block
    // takes it. Valid stays high into the next call unless a gap follows.
    task automatic send_item(input recon_item_t it);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        kind       <= it.kind;
        coef_a     <= it.coef[0];
        coef_b     <= it.coef[1];
        coef_c     <= it.coef[2];
        coef_d     <= it.coef[3];
        random_bit <= it.dither;
        hint_in_a  <= it.hint[0];
        hint_in_b  <= it.hint[1];
        hint_in_c  <= it.hint[2];
        hint_in_d  <= it.hint[3];
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 10);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else begin
                burst_left--;
            end
        end
    endtask

    // Hint mode with the smallest and largest coefficients, values right at
    // q, both dither values, and junk on the hint inputs.
    task automatic test_hint_extremes();
        recon_item_t it;
        logic [13:0] corner[4];
        corner = '{14'd0, 14'(LRU_Q - 1), 14'(LRU_Q), 14'(LRU_COEF_MAX)};
        for (int c = 0; c < 4; c++) begin
            for (int b = 0; b < 2; b++) begin
                it        = random_item();
                it.kind   = LRU_KIND_HINT;
                it.dither = 1'(b);
                for (int i = 0; i < 4; i++) begin
                    it.coef[i] = corner[(c + i) % 4];
                end
                send_item(it);
            end
        end
    endtask

    // Recover mode with coefficient corners against every hint value, and
    // the dither bit both set and clear to show it is ignored.
    task automatic test_recover_extremes();
        recon_item_t it;
        for (int h = 0; h < 4; h++) begin
            it        = random_item();
            it.kind   = LRU_KIND_RECOVER;
            it.dither = 1'b1;
            for (int i = 0; i < 4; i++) begin
                it.coef[i] = (h[0]) ? 14'(LRU_COEF_MAX) : 14'd0;
                it.hint[i] = 2'(h);
            end
            send_item(it);
            it.dither = 1'b0;
            for (int i = 0; i < 4; i++) begin
                it.coef[i] = (h[0]) ? 14'(LRU_Q) : 14'(LRU_Q - 1);
                it.hint[i] = 2'(3 - h);
            end
            send_item(it);
        end
    endtask

    // Hint mode around the selection point: coefficients near q/4 sit close
    // to a multiple of 2q after scaling, those near q/8 sit far from one.
    task automatic test_rounding_select();
        recon_item_t it;
        int unsigned base[3];
        base = '{LRU_Q / 4, LRU_Q / 8, 3 * LRU_Q / 8};
        for (int k = 0; k < 3; k++) begin
            for (int b = 0; b < 2; b++) begin
                it        = random_item();
                it.kind   = LRU_KIND_HINT;
                it.dither = 1'(b);
                for (int i = 0; i < 4; i++) begin
                    it.coef[i] = 14'(base[k] + i);
                end
                send_item(it);
            end
        end
    endtask

    // Matched pairs: the hints the block gives for one group feed a recover
    // transaction on a noisy copy of the same group. Small noise should give
    // back the key bit, large noise exercises the failing side.
    task automatic test_hint_recover_pairs(input int pairs);
        recon_item_t   it;
        recon_result_t hints;
        int            spread;
        int            noisy;
        for (int n = 0; n < pairs; n++) begin
            it      = random_item();
            it.kind = LRU_KIND_HINT;
            send_item(it);
            hints   = reconcile(it);
            spread  = ($urandom_range(0, 4) == 0) ? LRU_Q / 2 : $urandom_range(0, 400);
            it.kind = LRU_KIND_RECOVER;
            for (int i = 0; i < 4; i++) begin
                noisy = int'(it.coef[i]) + $urandom_range(0, 2 * spread) - spread;
                if (noisy < 0) begin
                    noisy = 0;
                end
                if (noisy > LRU_COEF_MAX) begin
                    noisy = LRU_COEF_MAX;
                end
                it.coef[i] = 14'(noisy);
                it.hint[i] = hints.hint[i];
            end
            it.dither = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // Unrelated random transactions in both modes.
    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
        end
    endtask

    // The receiver runs its own stall pattern, switching by its counter
    // between always ready, mostly ready, mostly stalled and a periodic
    // pattern set by the low bits of the counter.
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_phase[4:0] < 5'd6);
        endcase
    end

    // Predict each accepted transaction and check each delivered result.
    // The prediction is queued first so that a result in the same cycle as
    // its input would still find it.
    always @(posedge clk)
    begin
        recon_result_t want;
        recon_result_t got;
        recon_item_t   seen;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                seen.kind   = kind;
                seen.coef   = {coef_d, coef_c, coef_b, coef_a};
                seen.dither = random_bit;
                seen.hint   = {hint_in_d, hint_in_c, hint_in_b, hint_in_a};
                pending_results.push_back(reconcile(seen));
            end
            if (out_valid && out_ready) begin
                got.hint = {hint_out_d, hint_out_c, hint_out_b, hint_out_a};
                got.key  = key_bit;
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: result with nothing expected: hints %0d %0d %0d %0d key %0d",
                                 $realtime, got.hint[0], got.hint[1], got.hint[2],
                                 got.hint[3], got.key);
                    end
                end
                else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: hints %0d %0d %0d %0d key %0d, expected %0d %0d %0d %0d key %0d",
                                     $realtime, got.hint[0], got.hint[1], got.hint[2],
                                     got.hint[3], got.key, want.hint[0], want.hint[1],
                                     want.hint[2], want.hint[3], want.key);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either side means the
    // block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hint_extremes();
        test_recover_extremes();
        test_rounding_select();

        // Back-to-back traffic first, then bursts with gaps.
        gaps_on = 1'b0;
        test_hint_recover_pairs(150);
        test_random_mix(150);
        gaps_on = 1'b1;
        test_hint_recover_pairs(150);
        test_random_mix(200);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        // Give a stray extra result time to show up.
        repeat (20) @(posedge clk);

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ lattice_reconciliation_unit.f @@
design/lru_pkg.sv
design/lru_lane.sv
design/lru_combine.sv
design/lattice_reconciliation_unit.sv
dv/tb.sv
